FILE: src/psarw_pkg.sv
`default_nettype none
package psarw_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_DECIDE,
    S_RANK,
    S_RANK_END,
    S_CMP,
    S_CLASSIFY,
    S_SWEEP,
    S_SWEEP_END,
    S_BIT_RD,
    S_BIT_CHK,
    S_RESP
  } state_t;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_REPLAY  = 2'd1,
    ST_CLEARED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ACT_DONE,
    ACT_SWEEP,
    ACT_BIT
  } act_t;

  localparam logic [1:0] CFG_WINDOW_SIZE  = 2'd0;
  localparam logic [1:0] CFG_SENDER_LIMIT = 2'd1;
  localparam logic [1:0] CFG_RESTART_THR  = 2'd2;

  localparam logic [8:0]  WINDOW_SIZE_RST = 9'd64;
  localparam logic [4:0]  SENDER_LIMIT_RST = 5'd0;
  localparam logic [63:0] RESTART_THR_RST = 64'd2147483648;

  localparam int WORD_BITS = 64;

  typedef struct packed {
    logic load;
    logic clear;
    logic scan;
    logic decide;
    logic rank;
    logic cmp;
    logic classify;
    logic sweep;
    logic bit_rd;
    logic bit_chk;
  } cmd_t;

  typedef struct packed {
    act_t    act;
    status_t result;
  } sts_t;

endpackage
`default_nettype wire

FILE: src/psarw_ctrl.sv
`default_nettype none
module psarw_ctrl #(
  parameter int MAX_SLOTS = 16,
  parameter int WINDOW_WORDS = 4,
  localparam int SW = $clog2(MAX_SLOTS),
  localparam int WW = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_command,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [1:0]            out_status,
  output psarw_pkg::cmd_t       cmd,
  output logic [SW-1:0]         idx,
  output logic [WW-1:0]         wi,
  input  wire psarw_pkg::sts_t  sts
);
  import psarw_pkg::*;

  localparam logic [SW-1:0] IDX_LAST = SW'(MAX_SLOTS - 1);
  localparam logic [WW-1:0] WI_LAST = WW'(WINDOW_WORDS - 1);

  state_t          state_r, state_nxt;
  logic [SW-1:0]   idx_r, idx_nxt;
  logic [WW-1:0]   wi_r, wi_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    wi_r         <= wi_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    wi_nxt         = wi_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    cmd            = '0;
    in_ready       = 1'b0;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_command) begin
            cmd.clear = 1'b1;
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_SCAN_END;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      S_SCAN_END: state_nxt = S_DECIDE;
      S_DECIDE: begin
        cmd.decide = 1'b1;
        idx_nxt    = '0;
        state_nxt  = S_RANK;
      end
      S_RANK: begin
        cmd.rank = 1'b1;
        if (idx_r == IDX_LAST) begin
          state_nxt = S_RANK_END;
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      S_RANK_END: state_nxt = S_CMP;
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_CLASSIFY;
      end
      S_CLASSIFY: begin
        cmd.classify = 1'b1;
        unique case (sts.act)
          ACT_SWEEP: begin
            wi_nxt    = WI_LAST;
            state_nxt = S_SWEEP;
          end
          ACT_BIT: state_nxt = S_BIT_RD;
          default: state_nxt = S_RESP;
        endcase
      end
      S_SWEEP: begin
        cmd.sweep = 1'b1;
        if (wi_r == '0) begin
          state_nxt = S_SWEEP_END;
        end else begin
          wi_nxt = wi_r - WW'(1);
        end
      end
      S_SWEEP_END: state_nxt = S_RESP;
      S_BIT_RD: begin
        cmd.bit_rd = 1'b1;
        state_nxt  = S_BIT_CHK;
      end
      S_BIT_CHK: begin
        cmd.bit_chk = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = sts.result;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign idx        = idx_r;
  assign wi         = wi_r;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

FILE: src/psarw_dp.sv
`default_nettype none
module psarw_dp #(
  parameter int MAX_SLOTS = 16,
  parameter int WINDOW_WORDS = 4,
  localparam int SW = $clog2(MAX_SLOTS),
  localparam int WW = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [63:0]      cfg_data,
  input  wire logic [31:0]      in_sender,
  input  wire logic [63:0]      in_seq_number,
  input  wire psarw_pkg::cmd_t  cmd,
  input  wire logic [SW-1:0]    idx,
  input  wire logic [WW-1:0]    wi,
  output psarw_pkg::sts_t       sts
);
  import psarw_pkg::*;

  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int AW = $clog2(MAX_SLOTS * WINDOW_WORDS);
  localparam logic [63:0] WIN_BITS = 64'(WINDOW_WORDS * WORD_BITS);

  // configuration
  logic [8:0]  win_size_r;
  logic [4:0]  limit_r;
  logic [63:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= WINDOW_SIZE_RST;
      limit_r    <= SENDER_LIMIT_RST;
      thr_r      <= RESTART_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:  win_size_r <= cfg_data[8:0];
        CFG_SENDER_LIMIT: limit_r    <= cfg_data[4:0];
        CFG_RESTART_THR:  thr_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // slot storage
  logic [31:0]   sender_mem [MAX_SLOTS];
  logic [63:0]   high_mem [MAX_SLOTS];
  logic [SW-1:0] rank_mem [MAX_SLOTS];
  logic [63:0]   win_mem [MAX_SLOTS * WINDOW_WORDS];

  logic [MAX_SLOTS-1:0] valid_r;
  logic [CW-1:0]        count_r;

  logic [31:0]   id_r;
  logic [63:0]   seq_r;

  logic          eval_r, rank_wr_r, sw_d_r;
  logic [SW-1:0] idx_d_r;
  logic [31:0]   sender_q;
  logic [SW-1:0] rank_q;
  logic [63:0]   hi_q;

  logic          hit_r, free_found_r, lru_found_r;
  logic [SW-1:0] hit_idx_r, hit_rank_r, free_idx_r, lru_idx_r, lru_rank_r;

  logic [SW-1:0] s_r, s_nxt, r_r, r_nxt;
  logic          fresh_r, fresh_nxt, incr_r, incr_nxt;
  logic [CW-1:0] lim;
  logic          full;

  logic          gt_r, eq_r;
  logic [63:0]   dup_r, ddn_r;
  logic [63:0]   win_eff;
  act_t          act_c;
  status_t       res_c, res_r;
  logic          clr_c, clr_r;
  logic [WW-1:0] wsh_r, bw_r, wi_d_r;
  logic [5:0]    bs_r, bp_r;

  logic [AW-1:0] base, addr_a, addr_b, addr_w;
  logic [WW-1:0] a_off, b_off;
  logic          a_ok, b_ok, aok_d_r, bok_d_r;
  logic [63:0]   wa_q, wb_q, sweep_word, bit_word;
  logic          bit_hit;
  logic [SW-1:0] rank_new;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r  <= in_sender;
      seq_r <= in_seq_number;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r    <= 1'b0;
      rank_wr_r <= 1'b0;
      sw_d_r    <= 1'b0;
      valid_r   <= '0;
      count_r   <= '0;
    end else begin
      eval_r    <= cmd.scan;
      rank_wr_r <= cmd.rank;
      sw_d_r    <= cmd.sweep;
      if (cmd.clear) begin
        valid_r <= '0;
        count_r <= '0;
      end else if (cmd.decide && !hit_r && !full) begin
        valid_r[s_nxt] <= 1'b1;
        count_r        <= count_r + CW'(1);
      end
    end
  end

  // registered reads of the slot arrays
  always_ff @(posedge clk) begin
    sender_q <= sender_mem[idx];
    idx_d_r  <= idx;
    if (cmd.decide && fresh_nxt) begin
      sender_mem[s_nxt] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    rank_q <= rank_mem[idx];
    if (rank_wr_r) begin
      rank_mem[idx_d_r] <= rank_new;
    end
  end

  always_ff @(posedge clk) begin
    hi_q <= high_mem[s_r];
    if (cmd.classify && act_c == ACT_SWEEP) begin
      high_mem[s_r] <= seq_r;
    end
  end

  // scan: find the sender, the first free slot and the least recent slot
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      lru_found_r  <= 1'b0;
    end else if (eval_r) begin
      if (valid_r[idx_d_r] && sender_q == id_r && !hit_r) begin
        hit_r      <= 1'b1;
        hit_idx_r  <= idx_d_r;
        hit_rank_r <= rank_q;
      end
      if (!valid_r[idx_d_r] && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_d_r;
      end
      if (valid_r[idx_d_r] && (!lru_found_r || rank_q > lru_rank_r)) begin
        lru_found_r <= 1'b1;
        lru_idx_r   <= idx_d_r;
        lru_rank_r  <= rank_q;
      end
    end
  end

  always_comb begin
    if (limit_r == 5'd0 || 32'(limit_r) > MAX_SLOTS) begin
      lim = CW'(MAX_SLOTS);
    end else begin
      lim = CW'(limit_r);
    end
    full = (count_r >= lim);
    if (hit_r) begin
      s_nxt     = hit_idx_r;
      fresh_nxt = 1'b0;
      incr_nxt  = 1'b0;
      r_nxt     = hit_rank_r;
    end else if (full) begin
      s_nxt     = lru_idx_r;
      fresh_nxt = 1'b1;
      incr_nxt  = 1'b0;
      r_nxt     = lru_rank_r;
    end else begin
      s_nxt     = free_idx_r;
      fresh_nxt = 1'b1;
      incr_nxt  = 1'b1;
      r_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      s_r     <= s_nxt;
      fresh_r <= fresh_nxt;
      incr_r  <= incr_nxt;
      r_r     <= r_nxt;
    end
  end

  // age every valid slot more recent than the chosen one
  always_comb begin
    if (idx_d_r == s_r) begin
      rank_new = '0;
    end else if (valid_r[idx_d_r] && (incr_r || rank_q < r_r)) begin
      rank_new = rank_q + SW'(1);
    end else begin
      rank_new = rank_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      gt_r  <= seq_r > hi_q;
      eq_r  <= seq_r == hi_q;
      dup_r <= seq_r - hi_q;
      ddn_r <= hi_q - seq_r;
    end
  end

  always_comb begin
    if (win_size_r == 9'd0) begin
      win_eff = 64'd1;
    end else if (64'(win_size_r) > WIN_BITS) begin
      win_eff = WIN_BITS;
    end else begin
      win_eff = 64'(win_size_r);
    end
    act_c = ACT_DONE;
    res_c = ST_REPLAY;
    clr_c = 1'b1;
    if (fresh_r) begin
      act_c = ACT_SWEEP;
      res_c = ST_ACCEPT;
    end else if (gt_r) begin
      act_c = ACT_SWEEP;
      res_c = ST_ACCEPT;
      clr_c = (dup_r >= WIN_BITS);
    end else if (eq_r) begin
      act_c = ACT_DONE;
    end else if (ddn_r >= thr_r) begin
      act_c = ACT_SWEEP;
      res_c = ST_ACCEPT;
    end else if (ddn_r >= win_eff) begin
      act_c = ACT_DONE;
    end else begin
      act_c = ACT_BIT;
      res_c = ST_ACCEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      res_r <= ST_CLEARED;
    end else if (cmd.classify) begin
      res_r <= res_c;
      clr_r <= clr_c;
      wsh_r <= dup_r[6 +: WW];
      bs_r  <= dup_r[5:0];
      bw_r  <= ddn_r[6 +: WW];
      bp_r  <= ddn_r[5:0];
    end else if (cmd.bit_chk) begin
      res_r <= bit_hit ? ST_REPLAY : ST_ACCEPT;
    end
  end

  // window words: read two source words, write one shifted word in the following cycle
  always_comb begin
    base   = AW'(32'(s_r) * WINDOW_WORDS);
    a_ok   = (wi >= wsh_r);
    b_ok   = (wi > wsh_r);
    a_off  = wi - wsh_r;
    b_off  = a_off - WW'(1);
    addr_a = base + AW'(cmd.sweep ? a_off : bw_r);
    addr_b = base + AW'(b_off);
    addr_w = base + AW'(sw_d_r ? wi_d_r : bw_r);

    sweep_word = '0;
    if (!clr_r) begin
      if (aok_d_r) begin
        sweep_word = wa_q << bs_r;
      end
      if (bok_d_r && bs_r != 6'd0) begin
        sweep_word = sweep_word | (wb_q >> (7'd64 - {1'b0, bs_r}));
      end
    end
    if (wi_d_r == '0) begin
      sweep_word[0] = 1'b1;
    end

    bit_hit  = wa_q[bp_r];
    bit_word = wa_q | (64'd1 << bp_r);
  end

  always_ff @(posedge clk) begin
    wa_q    <= win_mem[addr_a];
    wb_q    <= win_mem[addr_b];
    aok_d_r <= a_ok;
    bok_d_r <= b_ok;
    wi_d_r  <= wi;
    if (sw_d_r) begin
      win_mem[addr_w] <= sweep_word;
    end else if (cmd.bit_chk && !bit_hit) begin
      win_mem[addr_w] <= bit_word;
    end
  end

  assign sts.act    = act_c;
  assign sts.result = res_r;

endmodule
`default_nettype wire

FILE: src/per_sender_anti_replay_window_unit.sv
`default_nettype none
// Flow per item: the sender table is scanned and ranked, the sequence number compared and
//   classified, then the window is rewritten, one bit tested or nothing more done; a clear
//   goes straight to the response.
// Throughput: one item at a time. The next transfer is taken once the result is registered
//   and the unit is idle; a result is held while an earlier one still waits for out_ready.
// Reset (synchronous, rst_n low): empties the sender table at once, loads register defaults.
module per_sender_anti_replay_window_unit #(
  parameter int MAX_SLOTS = 16,
  parameter int WINDOW_WORDS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_command,
  input  wire logic [31:0] in_sender,
  input  wire logic [63:0] in_seq_number,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status
);
  import psarw_pkg::*;

  localparam int SW = $clog2(MAX_SLOTS);
  localparam int WW = (WINDOW_WORDS > 1) ? $clog2(WINDOW_WORDS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [SW-1:0] idx;
  logic [WW-1:0] wi;

  psarw_ctrl #(
    .MAX_SLOTS(MAX_SLOTS),
    .WINDOW_WORDS(WINDOW_WORDS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .cmd        (cmd),
    .idx        (idx),
    .wi         (wi),
    .sts        (sts)
  );

  psarw_dp #(
    .MAX_SLOTS(MAX_SLOTS),
    .WINDOW_WORDS(WINDOW_WORDS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_sender     (in_sender),
    .in_seq_number (in_seq_number),
    .cmd           (cmd),
    .idx           (idx),
    .wi            (wi),
    .sts           (sts)
  );

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.scan, cmd.decide, cmd.rank, cmd.cmp, cmd.classify,
              cmd.sweep, cmd.bit_rd, cmd.bit_chk}))
    else $error("more than one datapath step issued");

  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new transfer taken while an item is in progress");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result raised without an item in progress");

endmodule
`default_nettype wire
